### src/bws_pkg.sv
// Shared types, constants and helpers of the box-window sharpen block.
// Used by bws_ctrl, bws_dp and box_window_sharpen_core. No dependencies.
package bws_pkg;

  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 4096;
  localparam int MaxRadius  = 32;
  localparam int StoreRows  = 2 * MaxRadius + 1;
  localparam int StoreDepth = StoreRows * MaxWidth;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowBits    = $clog2(MaxHeight);
  localparam int SlotBits   = $clog2(StoreRows);
  localparam int AddrBits   = $clog2(StoreDepth);

  localparam logic [11:0] WidthReset  = 12'd1920;
  localparam logic [12:0] HeightReset = 13'd1080;
  localparam logic [5:0]  RadiusReset = 6'd20;

  // register indexes of the configuration port
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_CHECK,
    S_START,
    S_SUM,
    S_DRAIN,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic write;
    logic win_init;
    logic win_step;
    logic div_start;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kind;
    logic input_done;
    logic emit_due;
    logic r_zero;
    logic win_last;
    logic pipe_busy;
    logic div_last;
    logic out_free;
  } ctrl_stat_t;

  // row modulo StoreRows: reciprocal estimate, never too high, then one correction
  function automatic logic [SlotBits-1:0] row_slot(input logic [RowBits-1:0] row);
    logic [21:0] prod;
    logic [5:0]  q;
    logic [12:0] rem;
    prod = {10'd0, row} * 22'd1008;
    q    = prod[21:16];
    rem  = {1'b0, row} - ({7'd0, q} * 13'd65);
    if (rem >= 13'(StoreRows)) begin
      rem = rem - 13'(StoreRows);
    end
    return rem[SlotBits-1:0];
  endfunction

endpackage

### src/bws_ctrl.sv
// Controller state machine of the box-window sharpen block.
// Depends on bws_pkg; drives bws_dp through command and status structs.
module bws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bws_pkg::ctrl_stat_t stat_i,
  output bws_pkg::ctrl_cmd_t  cmd_o
);
  import bws_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE: begin
        if (stat_i.input_done) state_d = S_START;
        else if (stat_i.kind)  state_d = S_IDLE;
        else                   state_d = S_CHECK;
      end
      S_CHECK:  state_d = stat_i.emit_due ? S_START : S_IDLE;
      S_START:  state_d = stat_i.r_zero ? S_OUT : S_SUM;
      S_SUM:    if (stat_i.win_last) state_d = S_DRAIN;
      S_DRAIN:  if (!stat_i.pipe_busy) state_d = S_DIV;
      S_DIV:    if (stat_i.div_last) state_d = S_OUT;
      S_OUT:    if (stat_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECIDE: cmd_o.write     = !stat_i.input_done && !stat_i.kind;
      S_START:  cmd_o.win_init  = !stat_i.r_zero;
      S_SUM:    cmd_o.win_step  = 1'b1;
      S_DRAIN:  cmd_o.div_start = !stat_i.pipe_busy;
      S_DIV:    cmd_o.div_step  = 1'b1;
      S_OUT:    cmd_o.emit      = stat_i.out_free;
      default:  cmd_o           = '0;
    endcase
  end

endmodule

### src/bws_dp.sv
// Datapath of the box-window sharpen block: config, line store, window sum,
// divider and output register. Depends on bws_pkg; commanded by bws_ctrl.
module bws_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i,
  input  logic                kind_i,
  input  logic [15:0]         sample_i,
  input  bws_pkg::ctrl_cmd_t  cmd_i,
  output bws_pkg::ctrl_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [17:0]  sharpened_o,
  output logic                last_o
);
  import bws_pkg::*;

  // configuration registers
  logic [11:0] fw_q;
  logic [12:0] fh_q;
  logic [5:0]  rad_q;
  logic        cfg_wr;
  assign cfg_wr = cfg_valid_i && (cfg_index_i == RegWidth || cfg_index_i == RegHeight ||
                                  cfg_index_i == RegRadius);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= WidthReset;
      fh_q  <= HeightReset;
      rad_q <= RadiusReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWidth:  fw_q  <= cfg_data_i[11:0];
        RegHeight: fh_q  <= cfg_data_i;
        RegRadius: rad_q <= cfg_data_i[5:0];
        default:   ;
      endcase
    end
  end

  // effective frame geometry
  logic [11:0] w;
  logic [12:0] h;
  logic [5:0]  r;
  assign w = (fw_q == 12'd0) ? 12'd1 : ((fw_q > 12'(MaxWidth)) ? 12'(MaxWidth) : fw_q);
  assign h = (fh_q == 13'd0) ? 13'd1 : ((fh_q > 13'(MaxHeight)) ? 13'(MaxHeight) : fh_q);
  assign r = (rad_q > 6'(MaxRadius)) ? 6'(MaxRadius) : rad_q;

  // derived constants, registered off the config
  logic [17:0] delay_q;
  logic [11:0] div_q;
  logic [11:0] rsq;
  logic [5:0]  rm1;
  assign rsq = {6'd0, r} * {6'd0, r};
  assign rm1 = r - 6'd1;

  always_ff @(posedge clk_i) begin
    delay_q <= (r == 6'd0) ? 18'd0 : ({12'd0, rm1} * {6'd0, w}) + {12'd0, rm1};
    div_q   <= 12'({rsq[9:0], 2'b00} - 12'd1);
  end

  // captured input word
  logic        kind_q;
  logic [15:0] sample_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      sample_q <= sample_i;
    end
  end

  // frame positions
  logic [ColBits-1:0]  in_col_q, out_col_q;
  logic [RowBits-1:0]  in_row_q, out_row_q;
  logic [SlotBits-1:0] in_slot_q;
  logic                input_done_q;
  logic [23:0]         pending_q;
  logic                is_last;
  logic                restart;

  assign is_last = ({1'b0, out_row_q} == h - 13'd1) && ({1'b0, out_col_q} == w - 12'd1);
  assign restart = cfg_wr || (cmd_i.emit && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q     <= '0;
      in_row_q     <= '0;
      in_slot_q    <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      input_done_q <= 1'b0;
      pending_q    <= '0;
    end else if (restart) begin
      in_col_q     <= '0;
      in_row_q     <= '0;
      in_slot_q    <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      input_done_q <= 1'b0;
      pending_q    <= '0;
    end else if (cmd_i.write) begin
      pending_q <= pending_q + 24'd1;
      if ({1'b0, in_col_q} + 12'd1 >= w) begin
        in_col_q  <= '0;
        in_row_q  <= in_row_q + 1'b1;
        in_slot_q <= (in_slot_q == SlotBits'(StoreRows - 1)) ? '0 : in_slot_q + 1'b1;
        if ({1'b0, in_row_q} + 13'd1 >= h) input_done_q <= 1'b1;
      end else begin
        in_col_q <= in_col_q + 1'b1;
      end
    end else if (cmd_i.emit) begin
      pending_q <= pending_q - 24'd1;
      if ({1'b0, out_col_q} + 12'd1 >= w) begin
        out_col_q <= '0;
        out_row_q <= out_row_q + 1'b1;
      end else begin
        out_col_q <= out_col_q + 1'b1;
      end
    end
  end

  // window counters
  logic [5:0] ry_q, cx_q;
  logic [6:0] span_m1;
  logic       cx_end;
  assign span_m1 = {r, 1'b0} - 7'd1;
  assign cx_end  = ({1'b0, cx_q} == span_m1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init) begin
      ry_q <= '0;
      cx_q <= '0;
    end else if (cmd_i.win_step) begin
      if (cx_end) begin
        cx_q <= '0;
        ry_q <= ry_q + 6'd1;
      end else begin
        cx_q <= cx_q + 6'd1;
      end
    end
  end

  // stage 1: clamped sample position
  logic signed [13:0] row_raw;
  logic signed [12:0] col_raw;
  logic [RowBits-1:0] crow;
  logic [ColBits-1:0] ccol;
  assign row_raw = $signed({2'b00, out_row_q}) - $signed({8'd0, r}) + $signed({8'd0, ry_q});
  assign col_raw = $signed({2'b00, out_col_q}) - $signed({7'd0, r}) + $signed({7'd0, cx_q});

  always_comb begin
    if (row_raw < 0)                          crow = '0;
    else if ({1'b0, row_raw[12:0]} >= {1'b0, h}) crow = 12'(h - 13'd1);
    else                                      crow = row_raw[RowBits-1:0];
    if (col_raw < 0)                          ccol = '0;
    else if ({1'b0, col_raw[11:0]} >= {1'b0, w})
                                              ccol = 11'(w - 12'd1);
    else                                      ccol = col_raw[ColBits-1:0];
  end

  logic               v1_q, v2_q, skip1_q, skip2_q;
  logic [RowBits-1:0] crow_q;
  logic [ColBits-1:0] ccol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.win_step;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    crow_q  <= crow;
    ccol_q  <= ccol;
    skip1_q <= (ry_q == r) && (cx_q == r);
    skip2_q <= skip1_q;
  end

  // line store: one write port, one registered read port
  logic [15:0]         mem [StoreDepth];
  logic [15:0]         rd_q;
  logic [AddrBits-1:0] wr_addr, rd_addr;
  assign wr_addr = {in_slot_q, in_col_q};
  assign rd_addr = {row_slot(crow_q), ccol_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) mem[wr_addr] <= sample_q;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
  end

  // stage 2: accumulate, keep the centre aside
  logic [27:0] acc_q;
  logic [15:0] centre_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init) begin
      acc_q <= '0;
    end else if (v2_q) begin
      if (skip2_q) centre_q <= rd_q;
      else         acc_q    <= acc_q + 28'(rd_q);
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [27:0] quo_q;
  logic [11:0] rem_q;
  logic [4:0]  dcnt_q;
  logic [12:0] trial;
  assign trial = {rem_q, quo_q[27]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q  <= acc_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (trial >= {1'b0, div_q}) begin
        rem_q <= 12'(trial - {1'b0, div_q});
        quo_q <= {quo_q[26:0], 1'b1};
      end else begin
        rem_q <= trial[11:0];
        quo_q <= {quo_q[26:0], 1'b0};
      end
    end
  end

  // output register
  logic              out_valid_q;
  logic [17:0]       res_q;
  logic              last_q;
  logic [17:0]       res_d;
  assign res_d = (r == 6'd0) ? 18'd0 : ({1'b0, centre_q, 1'b0} - quo_q[17:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q  <= res_d;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sharpened_o = $signed(res_q);
  assign last_o      = last_q;

  // status
  assign stat_o.kind       = kind_q;
  assign stat_o.input_done = input_done_q;
  assign stat_o.emit_due   = pending_q > {6'd0, delay_q};
  assign stat_o.r_zero     = (r == 6'd0);
  assign stat_o.win_last   = cx_end && ({1'b0, ry_q} == span_m1);
  assign stat_o.pipe_busy  = v1_q || v2_q;
  assign stat_o.div_last   = (dcnt_q == 5'd27);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_slot_q < SlotBits'(StoreRows)) else $error("line store slot out of range");
  a_no_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.write && input_done_q)) else $error("sample written after frame end");
  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> pending_q != 24'd0) else $error("result with nothing pending");
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q) else $error("result word not held");

endmodule

### src/box_window_sharpen_core.sv
// Top level of the box-window sharpen block.
// Depends on bws_pkg, bws_ctrl and bws_dp.
//
// Usage: pixel words (kind_i = 0, sample_i) enter in raster order on the
// in_valid_i / in_ready_o channel; flush words (kind_i = 1) drain the tail
// once the whole frame is in. Each result word (sharpened_o, last_o) leaves
// on out_valid_o / out_ready_i; last_o marks the frame's final pixel.
// Configuration writes (frame width, height, radius) use cfg_valid_i with
// cfg_index_i / cfg_data_i, are always ready, and restart the frame.
// Results trail pixels by (R-1)*W+(R-1) words. A pixel word with no result
// due, or a flush word before the frame is in, is taken without a result.
// A word with a result waits on the window sum, set by the single read port
// of the line store (one window sample a cycle), and on the bit-serial
// divider. A radius of zero gives 0 with no sum or division. A finished
// result sits in the output register; the next word is taken while it
// waits, and only the following result stalls on it.
// Reset clears all positions and loads width 1920, height 1080, radius 20;
// the line store needs no clearing.
module box_window_sharpen_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [15:0]        sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] sharpened_o,
  output logic               last_o
);
  import bws_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (kind_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sharpened_o (sharpened_o),
    .last_o      (last_o)
  );

endmodule
